>>> rtl/f2t_pkg.sv
// constants, payload types, status codes and sequencer states of the fpkm-to-tpm normalizer
// no dependencies; imported by fpkm_to_tpm_normalizer

package f2t_pkg;

   localparam int SUM_WIDTH    = 48;
   localparam int VALUE_WIDTH  = 32;
   localparam int OUT_WIDTH    = 48;
   localparam int MCOUNT_WIDTH = 32;
   localparam int ZCOUNT_WIDTH = 16;
   localparam int STATUS_WIDTH = 3;

   // 1e6 in q.16
   localparam int NUM_WIDTH = 36;
   localparam logic [NUM_WIDTH-1:0] SCALE_NUM = 36'd65536000000;

   localparam int MANT_WIDTH   = 32;
   localparam int DIV_PRESHIFT = SUM_WIDTH - NUM_WIDTH;
   localparam int SHIFT_BASE   = DIV_PRESHIFT + MANT_WIDTH - 1;
   localparam int MAX_LSHIFT   = SUM_WIDTH - 1 - SHIFT_BASE;
   localparam int SHIFT_WIDTH  = 8;
   localparam int ALIGN_WIDTH  = $clog2(SUM_WIDTH);
   localparam int BIT_WIDTH    = $clog2(MANT_WIDTH);
   localparam int PROD_WIDTH   = 2 * MANT_WIDTH;
   localparam int Q_WIDTH      = PROD_WIDTH + MAX_LSHIFT;

   localparam logic KIND_SUM   = 1'b0;
   localparam logic KIND_SCALE = 1'b1;

   typedef enum logic [STATUS_WIDTH-1:0] {
      STATUS_OK        = 3'd0,
      STATUS_REJECTED  = 3'd1,
      STATUS_ZERO      = 3'd2,
      STATUS_NEGATIVE  = 3'd3,
      STATUS_SATURATED = 3'd4
   } status_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_ALIGN,
      ST_DIVIDE,
      ST_MULT,
      ST_ROUND,
      ST_FINISH
   } state_type;

   typedef struct packed {
      logic                          kind;
      logic signed [VALUE_WIDTH-1:0] sample_value;
      logic                          is_missing;
      logic                          column_start;
   } req_payload_type;

   typedef struct packed {
      logic signed [OUT_WIDTH-1:0] tpm_value;
      status_type                  status;
      logic [MCOUNT_WIDTH-1:0]     missing_total;
      logic [ZCOUNT_WIDTH-1:0]     zero_columns;
   } rsp_payload_type;

endpackage

>>> rtl/fpkm_to_tpm_normalizer.sv
// fpkm-to-tpm normalizer top level: sum pass, per-column reciprocal, scale pass
// depends on f2t_pkg

// One transaction is taken at a time. A sum-pass transaction has its result
// registered at the accepting edge, and the next transaction can follow in
// the next cycle unless the result register is stalled. A scale-pass
// transaction with a positive total and a present value goes through the one
// 32x32 multiplier (ST_MULT) and the rounding shifter (ST_ROUND) to ST_FINISH;
// one with a zero or negative total or a missing value skips both. The first
// scale-pass transaction of a column with a positive total first forms the
// reciprocal on a shared compare/subtract unit: alignment of the divisor, then
// 32 quotient bits. A new transaction is accepted only while the sequencer is
// idle and the result register is empty or being drained.

module fpkm_to_tpm_normalizer (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_stall,
   input  f2t_pkg::req_payload_type req_payload,
   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   output f2t_pkg::rsp_payload_type rsp_payload,
   input  logic                     csr_write_en,
   input  logic                     csr_write_data
);
   import f2t_pkg::*;

   localparam logic [SUM_WIDTH:0] DIV_INIT =
      (SUM_WIDTH+1)'(SCALE_NUM) << DIV_PRESHIFT;
   localparam logic [Q_WIDTH-1:0] LIM_POS = (Q_WIDTH)'({1'b0, {(OUT_WIDTH-1){1'b1}}});
   localparam logic [Q_WIDTH-1:0] LIM_NEG = (Q_WIDTH)'({1'b1, {(OUT_WIDTH-1){1'b0}}});
   localparam logic signed [SUM_WIDTH-1:0] SUM_MAX = {1'b0, {(SUM_WIDTH-1){1'b1}}};
   localparam logic signed [SUM_WIDTH-1:0] SUM_MIN = {1'b1, {(SUM_WIDTH-1){1'b0}}};

   state_type state_ff, state_in;

   logic                          maz_ff, maz_in;
   logic signed [SUM_WIDTH-1:0]   sum_ff, sum_in;
   logic                          ready_ff, ready_in;
   logic [MCOUNT_WIDTH-1:0]       mcount_ff, mcount_in;
   logic [ZCOUNT_WIDTH-1:0]       zcount_ff, zcount_in;
   logic [MANT_WIDTH-1:0]         mant_ff, mant_in;
   logic signed [SHIFT_WIDTH-1:0] shift_ff, shift_in;

   logic [SUM_WIDTH:0]            rem_ff, rem_in;
   logic [SUM_WIDTH-1:0]          dvs_ff, dvs_in;
   logic [ALIGN_WIDTH-1:0]        align_ff, align_in;
   logic [BIT_WIDTH-1:0]          bit_ff, bit_in;

   req_payload_type               item_ff, item_in;
   logic [MANT_WIDTH-1:0]         mag_ff, mag_in;
   logic [PROD_WIDTH-1:0]         prod_ff, prod_in;
   logic [Q_WIDTH-1:0]            q_ff, q_in;

   logic                          rsp_valid_ff, rsp_valid_in;
   rsp_payload_type               rsp_ff, rsp_in;

   logic                          req_accept;
   logic                          sum_pos, sum_zero, sum_neg;
   logic signed [SUM_WIDTH-1:0]   base_sum;
   logic signed [SUM_WIDTH:0]     sum_ext;
   logic [SUM_WIDTH:0]            cmp_b, cmp_diff;
   logic                          cmp_ge;
   logic [PROD_WIDTH:0]           rnd_sum, rnd_bit;
   logic [SHIFT_WIDTH-1:0]        shr_amt, shl_amt;
   logic [Q_WIDTH-1:0]            lim, sat_mag;
   logic                          sat;
   logic [OUT_WIDTH-1:0]          scaled;

   assign req_stall   = (state_ff != ST_IDLE) || (rsp_valid_ff && rsp_stall);
   assign req_accept  = req_valid && !req_stall;
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

   assign sum_neg  = sum_ff[SUM_WIDTH-1];
   assign sum_zero = (sum_ff == '0);
   assign sum_pos  = !sum_neg && !sum_zero;

   // shared compare/subtract unit: alignment tests rem >= 2*dvs, division rem >= dvs
   assign cmp_b    = (state_ff == ST_ALIGN) ? {dvs_ff, 1'b0} : {1'b0, dvs_ff};
   assign cmp_ge   = (rem_ff >= cmp_b);
   assign cmp_diff = rem_ff - cmp_b;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         maz_ff       <= 1'b1;
         sum_ff       <= '0;
         ready_ff     <= 1'b0;
         mcount_ff    <= '0;
         zcount_ff    <= '0;
         mant_ff      <= '0;
         shift_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         maz_ff       <= maz_in;
         sum_ff       <= sum_in;
         ready_ff     <= ready_in;
         mcount_ff    <= mcount_in;
         zcount_ff    <= zcount_in;
         mant_ff      <= mant_in;
         shift_ff     <= shift_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff   <= rem_in;
      dvs_ff   <= dvs_in;
      align_ff <= align_in;
      bit_ff   <= bit_in;
      item_ff  <= item_in;
      mag_ff   <= mag_in;
      prod_ff  <= prod_in;
      q_ff     <= q_in;
      rsp_ff   <= rsp_in;
   end

   always_comb begin
      state_in     = state_ff;
      maz_in       = csr_write_en ? csr_write_data : maz_ff;
      sum_in       = sum_ff;
      ready_in     = ready_ff;
      mcount_in    = mcount_ff;
      zcount_in    = zcount_ff;
      mant_in      = mant_ff;
      shift_in     = shift_ff;
      rem_in       = rem_ff;
      dvs_in       = dvs_ff;
      align_in     = align_ff;
      bit_in       = bit_ff;
      item_in      = item_ff;
      mag_in       = mag_ff;
      prod_in      = prod_ff;
      q_in         = q_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_in       = rsp_ff;

      base_sum = req_payload.column_start ? '0 : sum_ff;
      sum_ext  = {base_sum[SUM_WIDTH-1], base_sum}
               + (SUM_WIDTH+1)'(req_payload.sample_value);

      shr_amt = shift_ff;
      shl_amt = -shift_ff;
      rnd_bit = (PROD_WIDTH+1)'(1) << (shr_amt - SHIFT_WIDTH'(1));
      rnd_sum = {1'b0, prod_ff} + rnd_bit;

      lim     = item_ff.sample_value[VALUE_WIDTH-1] ? LIM_NEG : LIM_POS;
      sat     = (q_ff > lim);
      sat_mag = sat ? lim : q_ff;
      scaled  = item_ff.sample_value[VALUE_WIDTH-1] ? -sat_mag[OUT_WIDTH-1:0]
                                                   : sat_mag[OUT_WIDTH-1:0];

      unique case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               item_in = req_payload;
               mag_in  = req_payload.sample_value[VALUE_WIDTH-1]
                       ? MANT_WIDTH'(-req_payload.sample_value)
                       : MANT_WIDTH'(req_payload.sample_value);
               if (req_payload.kind == KIND_SUM) begin
                  ready_in = 1'b0;
                  rsp_in.tpm_value = '0;
                  rsp_in.status    = STATUS_OK;
                  if (req_payload.is_missing) begin
                     sum_in = base_sum;
                     if (mcount_ff != '1) begin
                        mcount_in = mcount_ff + MCOUNT_WIDTH'(1);
                     end
                     rsp_in.status = maz_ff ? STATUS_OK : STATUS_REJECTED;
                  end else if (sum_ext[SUM_WIDTH] != sum_ext[SUM_WIDTH-1]) begin
                     sum_in        = sum_ext[SUM_WIDTH] ? SUM_MIN : SUM_MAX;
                     rsp_in.status = STATUS_SATURATED;
                  end else begin
                     sum_in = sum_ext[SUM_WIDTH-1:0];
                  end
                  rsp_in.missing_total = mcount_in;
                  rsp_in.zero_columns  = zcount_ff;
                  rsp_valid_in = 1'b1;
               end else begin
                  ready_in = 1'b1;
                  if (req_payload.column_start || !ready_ff) begin
                     if (sum_zero && zcount_ff != '1) begin
                        zcount_in = zcount_ff + ZCOUNT_WIDTH'(1);
                     end
                  end
                  if ((req_payload.column_start || !ready_ff) && sum_pos) begin
                     rem_in   = DIV_INIT;
                     dvs_in   = sum_ff;
                     align_in = '0;
                     state_in = ST_ALIGN;
                  end else if (sum_pos && !req_payload.is_missing) begin
                     state_in = ST_MULT;
                  end else begin
                     state_in = ST_FINISH;
                  end
               end
            end
         end
         ST_ALIGN: begin
            if (cmp_ge) begin
               dvs_in   = {dvs_ff[SUM_WIDTH-2:0], 1'b0};
               align_in = align_ff + ALIGN_WIDTH'(1);
            end else begin
               shift_in = SHIFT_WIDTH'(SHIFT_BASE) - SHIFT_WIDTH'(align_ff);
               bit_in   = '0;
               state_in = ST_DIVIDE;
            end
         end
         ST_DIVIDE: begin
            mant_in = {mant_ff[MANT_WIDTH-2:0], cmp_ge};
            rem_in  = cmp_ge ? {cmp_diff[SUM_WIDTH-1:0], 1'b0}
                             : {rem_ff[SUM_WIDTH-1:0], 1'b0};
            bit_in  = bit_ff + BIT_WIDTH'(1);
            if (bit_ff == BIT_WIDTH'(MANT_WIDTH - 1)) begin
               state_in = item_ff.is_missing ? ST_FINISH : ST_MULT;
            end
         end
         ST_MULT: begin
            prod_in  = mag_ff * mant_ff;
            state_in = ST_ROUND;
         end
         ST_ROUND: begin
            priority if (shift_ff > 0) begin
               q_in = Q_WIDTH'(rnd_sum >> shr_amt);
            end else if (shift_ff < 0) begin
               q_in = Q_WIDTH'(prod_ff) << shl_amt;
            end else begin
               q_in = Q_WIDTH'(prod_ff);
            end
            state_in = ST_FINISH;
         end
         ST_FINISH: begin
            rsp_in.tpm_value = '0;
            rsp_in.status    = STATUS_OK;
            if (item_ff.is_missing) begin
               priority if (!maz_ff) begin
                  rsp_in.status = STATUS_REJECTED;
               end else if (sum_zero) begin
                  rsp_in.status = STATUS_ZERO;
               end else if (sum_neg) begin
                  rsp_in.status = STATUS_NEGATIVE;
               end else begin
                  rsp_in.status = STATUS_OK;
               end
            end else if (sum_zero) begin
               rsp_in.status = STATUS_ZERO;
            end else if (sum_neg) begin
               rsp_in.tpm_value = OUT_WIDTH'(item_ff.sample_value);
               rsp_in.status    = STATUS_NEGATIVE;
            end else begin
               rsp_in.tpm_value = scaled;
               rsp_in.status    = sat ? STATUS_SATURATED : STATUS_OK;
            end
            rsp_in.missing_total = mcount_ff;
            rsp_in.zero_columns  = zcount_ff;
            rsp_valid_in = 1'b1;
            state_in     = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule
